### rtl/particle_repulsion_step_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for particle_repulsion_step
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef PARTICLE_REPULSION_STEP_ASSERT_SVH
`define PARTICLE_REPULSION_STEP_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define PRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define PRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prp_pkg.sv
// ---------------------------------------------------------------------------
// prp_pkg
// Types and constants shared by the particle repulsion step files.
// ---------------------------------------------------------------------------
package prp_pkg;

  localparam int POS_W  = 20;
  localparam int VEL_W  = 16;
  localparam int FRIC_W = 16;
  localparam int RAD_W  = 16;
  localparam int ACT_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  localparam pos_t HOME_POS = 20'd25600;

  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEL_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COUNT = 3'd4;

  localparam pos_t               RST_WORLD_WIDTH  = 20'd262144;
  localparam pos_t               RST_WORLD_HEIGHT = 20'd196608;
  localparam logic [FRIC_W-1:0]  RST_FRICTION     = 16'd63570;
  localparam logic [RAD_W-1:0]   RST_REPEL_RADIUS = 16'd3840;
  localparam logic [ACT_W-1:0]   RST_ACTIVE_COUNT = 7'd64;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_RESET  = 1'b1;

endpackage

### rtl/prp_if.sv
// ---------------------------------------------------------------------------
// prp_in_if / prp_out_if
// Valid-ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface prp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [prp_pkg::IDX_W-1:0]       particle;
  logic signed [prp_pkg::VEL_W-1:0] push_x;
  logic signed [prp_pkg::VEL_W-1:0] push_y;

  modport source (output valid, cmd, particle, push_x, push_y, input ready);
  modport sink   (input valid, cmd, particle, push_x, push_y, output ready);
endinterface

interface prp_out_if;
  logic                             valid;
  logic                             ready;
  logic [prp_pkg::POS_W-1:0]        new_x;
  logic [prp_pkg::POS_W-1:0]        new_y;
  logic signed [prp_pkg::VEL_W-1:0] new_vx;
  logic signed [prp_pkg::VEL_W-1:0] new_vy;

  modport source (output valid, new_x, new_y, new_vx, new_vy, input ready);
  modport sink   (input valid, new_x, new_y, new_vx, new_vy, output ready);
endinterface

### rtl/prp_ram.sv
// ---------------------------------------------------------------------------
// prp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module prp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/particle_repulsion_step.sv
// ---------------------------------------------------------------------------
// particle_repulsion_step
// Position and velocity store with a per-item repulsion and integration step.
// ---------------------------------------------------------------------------
// A reset item goes from idle straight to write-back, skipping the walk.
// An update item walks the n active particles and runs the force step for the k in range.
// The walk reads the particles one after another from the position RAM, each
// through RDQ, DQ, SQ and CMP; each one in range runs a bit-serial square root
// and divider before the next is read. After rst_n a clearing pass homes every
// particle; no item is accepted during it, configuration writes are taken as ever.
module particle_repulsion_step #(
  parameter int MAX_MOLECULES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  prp_in_if.sink                              in_ch,
  prp_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
  localparam int NW = AW + 1;
  localparam int FW = $clog2(MAX_MOLECULES) + 18;
  localparam int PW = 2 * prp_pkg::POS_W;
  localparam int VW = 2 * prp_pkg::VEL_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RDP   = 4'd2;
  localparam logic [3:0] ST_LDP   = 4'd3;
  localparam logic [3:0] ST_RDQ   = 4'd4;
  localparam logic [3:0] ST_DQ    = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_SQRT  = 4'd8;
  localparam logic [3:0] ST_DEN   = 4'd9;
  localparam logic [3:0] ST_NUM   = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_DAMP  = 4'd13;
  localparam logic [3:0] ST_VEL   = 4'd14;
  localparam logic [3:0] ST_WB    = 4'd15;

  logic [3:0] state_r, state_nxt;

  // Configuration registers.
  prp_pkg::pos_t                  world_width_r, world_height_r;
  logic [prp_pkg::FRIC_W-1:0]     friction_r;
  logic [prp_pkg::RAD_W-1:0]      repel_radius_r;
  logic [prp_pkg::ACT_W-1:0]      active_count_r;

  // Item and working registers.
  logic [AW-1:0]                  clr_cnt_r, p_r;
  logic                           cmd_r;
  logic [NW-1:0]                  q_r, n_r;
  prp_pkg::pos_t                  x_r, y_r;
  prp_pkg::vel_t                  vx_r, vy_r;
  logic signed [FW-1:0]           fx_r, fy_r;
  logic [31:0]                    thr2_r;
  logic signed [20:0]             dx_r, dy_r;
  logic [41:0]                    sx_r, sy_r;
  logic [31:0]                    s_r;
  logic [17:0]                    rem_r;
  logic [15:0]                    root_r;
  logic [3:0]                     cnt_r;
  logic [15:0]                    magx_r, magy_r, diff_r;
  logic [31:0]                    den_r;
  logic [39:0]                    remx_r, remy_r, den_sh_r;
  logic [7:0]                     qx_r, qy_r;
  logic signed [16:0]             dvx_r, dvy_r;
  logic signed [21:0]             xs_r, ys_r;
  prp_pkg::vel_t                  nvx_r, nvy_r;

  // Output register.
  logic                           out_valid_r;
  prp_pkg::pos_t                  out_x_r, out_y_r;
  prp_pkg::vel_t                  out_vx_r, out_vy_r;

  // RAM ports.
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr, rd_addr;
  logic [PW-1:0]                  pos_wdata, pos_rdata;
  logic [VW-1:0]                  vel_wdata, vel_rdata;

  prp_pkg::pos_t                  fin_x, fin_y;
  prp_pkg::vel_t                  fin_vx, fin_vy;

  logic signed [20:0]             dx_c, dy_c;
  logic [42:0]                    s_full;
  logic [19:0]                    rem_ext, trial;
  logic [39:0]                    remx_nxt, remy_nxt;
  logic                           bitx, bity;
  logic signed [FW:0]             vsx, vsy;
  logic signed [21:0]             xs_c, ys_c;
  logic signed [32:0]             dampx_c, dampy_c;
  logic                           in_fire, out_fire, wb_go;

  prp_ram #(.WIDTH(PW), .DEPTH(MAX_MOLECULES)) u_pos_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(pos_wdata),
    .raddr(rd_addr),
    .rdata(pos_rdata)
  );

  prp_ram #(.WIDTH(VW), .DEPTH(MAX_MOLECULES)) u_vel_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(vel_wdata),
    .raddr(rd_addr),
    .rdata(vel_rdata)
  );

  function automatic prp_pkg::vel_t sat_vel(input logic signed [FW:0] v);
    if (v > $signed((FW+1)'(32767))) begin
      return 16'sh7FFF;
    end else if (v < -$signed((FW+1)'(32768))) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic prp_pkg::vel_t neg_vel(input prp_pkg::vel_t v);
    if (v == 16'sh8000) begin
      return 16'sh7FFF;
    end
    return -v;
  endfunction

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign wb_go     = (state_r == ST_WB) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.new_x  = out_x_r;
  assign out_ch.new_y  = out_y_r;
  assign out_ch.new_vx = out_vx_r;
  assign out_ch.new_vy = out_vy_r;

  // Final values: home for a reset item, edge-checked step for an update.
  always_comb begin
    fin_x  = xs_r[19:0];
    fin_y  = ys_r[19:0];
    fin_vx = nvx_r;
    fin_vy = nvy_r;
    if (cmd_r == prp_pkg::CMD_RESET) begin
      fin_x  = prp_pkg::HOME_POS;
      fin_y  = prp_pkg::HOME_POS;
      fin_vx = '0;
      fin_vy = '0;
    end else begin
      if (xs_r > $signed({2'b00, world_width_r})) begin
        fin_x  = world_width_r;
        fin_vx = neg_vel(nvx_r);
      end else if (xs_r < 0) begin
        fin_x  = '0;
        fin_vx = neg_vel(nvx_r);
      end
      if (ys_r > $signed({2'b00, world_height_r})) begin
        fin_y  = world_height_r;
        fin_vy = neg_vel(nvy_r);
      end else if (ys_r < 0) begin
        fin_y  = '0;
        fin_vy = neg_vel(nvy_r);
      end
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = p_r;
    pos_wdata = {fin_x, fin_y};
    vel_wdata = {fin_vx, fin_vy};
    if (state_r == ST_CLEAR) begin
      wr_en     = 1'b1;
      wr_addr   = clr_cnt_r;
      pos_wdata = {prp_pkg::HOME_POS, prp_pkg::HOME_POS};
      vel_wdata = '0;
    end else if (wb_go) begin
      wr_en = 1'b1;
    end
    rd_addr = (state_r == ST_RDQ) ? q_r[AW-1:0] : p_r;
  end

  always_comb begin
    dx_c     = $signed({1'b0, x_r}) - $signed({1'b0, pos_rdata[PW-1:prp_pkg::POS_W]});
    dy_c     = $signed({1'b0, y_r}) - $signed({1'b0, pos_rdata[prp_pkg::POS_W-1:0]});
    s_full   = {1'b0, sx_r} + {1'b0, sy_r};
    rem_ext  = {rem_r, s_r[31:30]};
    trial    = {2'b00, root_r, 2'b01};
    bitx     = remx_r >= den_sh_r;
    bity     = remy_r >= den_sh_r;
    remx_nxt = bitx ? remx_r - den_sh_r : remx_r;
    remy_nxt = bity ? remy_r - den_sh_r : remy_r;
    dampx_c  = vx_r * $signed({1'b0, friction_r});
    dampy_c  = vy_r * $signed({1'b0, friction_r});
    vsx      = (FW+1)'(dvx_r) + (FW+1)'(fx_r);
    vsy      = (FW+1)'(dvy_r) + (FW+1)'(fy_r);
    xs_c     = $signed({2'b00, x_r}) + 22'(sat_vel(vsx));
    ys_c     = $signed({2'b00, y_r}) + 22'(sat_vel(vsy));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (32'(clr_cnt_r) == MAX_MOLECULES - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire && (32'(in_ch.particle) < MAX_MOLECULES)) begin
          state_nxt = (in_ch.cmd == prp_pkg::CMD_RESET) ? ST_WB : ST_RDP;
        end
      end
      ST_RDP:  state_nxt = ST_LDP;
      ST_LDP: begin
        if (active_count_r == '0 || repel_radius_r == '0) begin
          state_nxt = ST_DAMP;
        end else begin
          state_nxt = ST_RDQ;
        end
      end
      ST_RDQ:  state_nxt = ST_DQ;
      ST_DQ:   state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (s_full == '0 || s_full >= 43'(thr2_r)) begin
          state_nxt = (NW'(q_r + 1'b1) == n_r) ? ST_DAMP : ST_RDQ;
        end else begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: if (cnt_r == 4'd15) state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_NUM;
      ST_NUM:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 4'd7) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (NW'(q_r + 1'b1) == n_r) ? ST_DAMP : ST_RDQ;
      ST_DAMP: state_nxt = ST_VEL;
      ST_VEL:  state_nxt = ST_WB;
      ST_WB:   if (wb_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      world_width_r  <= prp_pkg::RST_WORLD_WIDTH;
      world_height_r <= prp_pkg::RST_WORLD_HEIGHT;
      friction_r     <= prp_pkg::RST_FRICTION;
      repel_radius_r <= prp_pkg::RST_REPEL_RADIUS;
      active_count_r <= prp_pkg::RST_ACTIVE_COUNT;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      end
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          prp_pkg::REG_WORLD_WIDTH:  world_width_r  <= cfg_data;
          prp_pkg::REG_WORLD_HEIGHT: world_height_r <= cfg_data;
          prp_pkg::REG_FRICTION:     friction_r     <= cfg_data[prp_pkg::FRIC_W-1:0];
          prp_pkg::REG_REPEL_RADIUS: repel_radius_r <= cfg_data[prp_pkg::RAD_W-1:0];
          prp_pkg::REG_ACTIVE_COUNT: active_count_r <= cfg_data[prp_pkg::ACT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.cmd;
      p_r   <= AW'(in_ch.particle);
      fx_r  <= FW'(in_ch.push_x);
      fy_r  <= FW'(in_ch.push_y);
    end
    if (wb_go) begin
      out_x_r  <= fin_x;
      out_y_r  <= fin_y;
      out_vx_r <= fin_vx;
      out_vy_r <= fin_vy;
    end
    case (state_r)
      ST_LDP: begin
        x_r    <= pos_rdata[PW-1:prp_pkg::POS_W];
        y_r    <= pos_rdata[prp_pkg::POS_W-1:0];
        vx_r   <= vel_rdata[VW-1:prp_pkg::VEL_W];
        vy_r   <= vel_rdata[prp_pkg::VEL_W-1:0];
        thr2_r <= repel_radius_r * repel_radius_r;
        q_r    <= '0;
        n_r    <= (32'(active_count_r) > MAX_MOLECULES) ? NW'(MAX_MOLECULES)
                                                        : NW'(active_count_r);
      end
      ST_DQ: begin
        dx_r <= dx_c;
        dy_r <= dy_c;
      end
      ST_SQ: begin
        sx_r <= 42'(dx_r * dx_r);
        sy_r <= 42'(dy_r * dy_r);
      end
      ST_CMP: begin
        s_r    <= s_full[31:0];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        if (s_full == '0 || s_full >= 43'(thr2_r)) begin
          q_r <= NW'(q_r + 1'b1);
        end
      end
      ST_SQRT: begin
        s_r   <= {s_r[29:0], 2'b00};
        cnt_r <= 4'(cnt_r + 1'b1);
        if (rem_ext >= trial) begin
          rem_r  <= 18'(rem_ext - trial);
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          rem_r  <= rem_ext[17:0];
          root_r <= {root_r[14:0], 1'b0};
        end
      end
      ST_DEN: begin
        den_r  <= root_r * repel_radius_r;
        diff_r <= repel_radius_r - root_r;
        magx_r <= dx_r[20] ? 16'(-dx_r) : dx_r[15:0];
        magy_r <= dy_r[20] ? 16'(-dy_r) : dy_r[15:0];
      end
      ST_NUM: begin
        remx_r   <= {32'(magx_r * diff_r), 8'h00};
        remy_r   <= {32'(magy_r * diff_r), 8'h00};
        den_sh_r <= {1'b0, den_r, 7'h00};
        cnt_r    <= '0;
      end
      ST_DIV: begin
        remx_r   <= remx_nxt;
        remy_r   <= remy_nxt;
        qx_r     <= {qx_r[6:0], bitx};
        qy_r     <= {qy_r[6:0], bity};
        den_sh_r <= {1'b0, den_sh_r[39:1]};
        cnt_r    <= 4'(cnt_r + 1'b1);
      end
      ST_ACC: begin
        fx_r <= dx_r[20] ? fx_r - FW'(qx_r) : fx_r + FW'(qx_r);
        fy_r <= dy_r[20] ? fy_r - FW'(qy_r) : fy_r + FW'(qy_r);
        q_r  <= NW'(q_r + 1'b1);
      end
      ST_DAMP: begin
        dvx_r <= dampx_c[32:16];
        dvy_r <= dampy_c[32:16];
      end
      ST_VEL: begin
        nvx_r <= sat_vel(vsx);
        nvy_r <= sat_vel(vsy);
        xs_r  <= xs_c;
        ys_r  <= ys_c;
      end
      default: ;
    endcase
  end

`include "particle_repulsion_step_assert.svh"

  `PRP_ASSERT_IMP(a_walk_in_range, state_r == ST_RDQ, q_r < n_r, "walk index beyond count")
  `PRP_ASSERT_IMP(a_root_below_radius, state_r == ST_DEN, root_r < repel_radius_r, "root too big")
  `PRP_ASSERT_IMP(a_write_window, wr_en, state_r == ST_CLEAR || state_r == ST_WB, "RAM write in walk")
  `PRP_ASSERT_NEXT(a_wb_loads_out, wb_go, out_valid_r, "result not loaded")

endmodule
